### design/bouncing_ball_physics_step_unit_assert.svh
// assertion macros for the ball step unit
`ifndef BOUNCING_BALL_PHYSICS_STEP_UNIT_ASSERT_SVH
`define BOUNCING_BALL_PHYSICS_STEP_UNIT_ASSERT_SVH

// same-cycle implication
`define BBPS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbps assertion failed");

// next-cycle implication
`define BBPS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbps assertion failed");

`endif

### design/bbps_pkg.sv
package bbps_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DROP_HEIGHT = 2'd0,
		CFG_DAMPING     = 2'd1,
		CFG_GRAVITY     = 2'd2
	} cfg_idx_t;

	localparam logic [18:0] DROP_RST  = 19'd131072;
	localparam logic [15:0] DAMP_RST  = 16'd58982;
	localparam logic [19:0] GRAV_RST  = 20'd642253;
	localparam logic [18:0] DROP_MIN  = 19'd39322;
	localparam logic [18:0] DROP_MAX  = 19'd262144;
	localparam logic [15:0] DT_MAX    = 16'd3277;

	localparam logic signed [23:0] RADIUS   = 24'sd32768;
	localparam logic signed [23:0] WALL_POS = 24'sd98304;
	localparam logic signed [23:0] WALL_NEG = -24'sd98304;
	localparam logic [47:0]        REST_SQ_LIMIT = 48'd96636765;

	typedef struct packed {
		logic [18:0] drop_height;
		logic [15:0] damping;
		logic [19:0] gravity;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic signed [24:0] a;
		logic signed [24:0] b;
	} mul_req_t;

	function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
		if (v > 36'sd8388607) begin
			return 24'sd8388607;
		end
		if (v < -36'sd8388608) begin
			return -24'sd8388608;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [35:0] sx36(input logic signed [23:0] v);
		return {{12{v[23]}}, v};
	endfunction

	function automatic logic signed [24:0] sx25(input logic signed [23:0] v);
		return {v[23], v};
	endfunction

	// product in q16 scaling, rounded toward minus infinity
	function automatic logic signed [35:0] q16(input logic signed [49:0] p);
		return {{2{p[49]}}, p[49:16]};
	endfunction

	function automatic logic [23:0] kinetic(input logic [47:0] sq);
		logic [30:0] e;
		e = sq[47:17];
		if (e > 31'd16777215) begin
			return 24'hFFFFFF;
		end
		return e[23:0];
	endfunction

endpackage

### design/bbps_ifs.sv
interface bbps_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] time_step;

	modport source(output valid, cmd, time_step, input ready);
	modport sink(input valid, cmd, time_step, output ready);
endinterface

interface bbps_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] vel_x;
	logic signed [23:0] vel_y;
	logic [15:0]        bounces;
	logic               resting;
	logic [23:0]        first_energy;
	logic [23:0]        last_energy;

	modport source(output valid, pos_x, pos_y, vel_x, vel_y, bounces, resting,
		first_energy, last_energy, input ready);
	modport sink(input valid, pos_x, pos_y, vel_x, vel_y, bounces, resting,
		first_energy, last_energy, output ready);
endinterface

interface bbps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bbps_pkg::CFG_IDX_W-1:0]  index;
	logic [bbps_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/bbps_cfg.sv
module bbps_cfg (
	input  logic            clk,
	input  logic            arst_n,
	bbps_cfg_if.sink        cfg,
	output bbps_pkg::cfg_t  regs
);

	logic [18:0] drop_q;
	logic [15:0] damp_q;
	logic [19:0] grav_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= bbps_pkg::DROP_RST;
			damp_q <= bbps_pkg::DAMP_RST;
			grav_q <= bbps_pkg::GRAV_RST;
		end else if (cfg.valid) begin
			case (bbps_pkg::cfg_idx_t'(cfg.index))
				bbps_pkg::CFG_DROP_HEIGHT: drop_q <= cfg.data[18:0];
				bbps_pkg::CFG_DAMPING:     damp_q <= cfg.data[15:0];
				bbps_pkg::CFG_GRAVITY:     grav_q <= cfg.data[19:0];
				default: ;
			endcase
		end
	end

	assign regs.drop_height = drop_q;
	assign regs.damping     = damp_q;
	assign regs.gravity     = grav_q;

endmodule

### design/bbps_mul.sv
module bbps_mul (
	input  logic                 clk,
	input  bbps_pkg::mul_req_t   req,
	output logic signed [49:0]   prod
);

	logic signed [49:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

	assign prod = prod_q;

endmodule

### design/bouncing_ball_physics_step_unit.sv
// channel   | dir | payload
// step_in   | in  | cmd, time_step
// step_out  | out | pos_x, pos_y, vel_x, vel_y, bounces, resting, first_energy, last_energy
// cfg       | in  | index, data (drop_height, damping, gravity)
//
// a reset command or a tick at rest goes straight to the output; a tick in the air updates
// vy, x and y, a contact adds damping; one 25x25 multiplier does every product
// arst_n returns the registers to their defaults and drops the ball from 2.0
// a finished word waits in the output register; the next word is accepted meanwhile
// step_in is not ready while a tick is in the sequencer, nor while a finished word
// waits for the output register to drain
module bouncing_ball_physics_step_unit (
	input  logic        clk,
	input  logic        arst_n,
	bbps_in_if.sink     step_in,
	bbps_out_if.source  step_out,
	bbps_cfg_if.sink    cfg
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VY_UPD,
		ST_PX_UPD,
		ST_PY_UPD,
		ST_SQ_X,
		ST_SQ_SUM,
		ST_FLOOR,
		ST_DAMP_Y,
		ST_DAMP_X,
		ST_KE_X,
		ST_KE_SUM,
		ST_KE_LOAD,
		ST_WALL,
		ST_WALL_DAMP,
		ST_DONE
	} state_t;

	state_t state_q;

	bbps_pkg::cfg_t     regs;
	bbps_pkg::mul_req_t req;
	logic signed [49:0] prod;

	logic signed [23:0] x_q, y_q, vx_q, vy_q;
	logic [15:0]        bounce_q;
	logic               rest_q;
	logic               awaiting_q;
	logic [23:0]        e_init_q, e_cur_q;
	logic [11:0]        dt_q;
	logic [47:0]        sq_q;

	logic               out_valid_q;
	logic signed [23:0] o_x_q, o_y_q, o_vx_q, o_vy_q;
	logic [15:0]        o_bounce_q;
	logic               o_rest_q;
	logic [23:0]        o_e_init_q, o_e_cur_q;

	logic               accept;
	logic [15:0]        dt_clamp;
	logic [18:0]        drop_clamp;
	logic signed [23:0] y_new;

	bbps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bbps_mul u_mul (
		.clk  (clk),
		.req  (req),
		.prod (prod)
	);

	assign step_in.ready = (state_q == ST_IDLE);
	assign accept        = step_in.valid && step_in.ready;

	assign dt_clamp = (step_in.time_step > bbps_pkg::DT_MAX) ? bbps_pkg::DT_MAX
		: step_in.time_step;

	always_comb begin
		drop_clamp = regs.drop_height;
		if (regs.drop_height < bbps_pkg::DROP_MIN) begin
			drop_clamp = bbps_pkg::DROP_MIN;
		end
		if (regs.drop_height > bbps_pkg::DROP_MAX) begin
			drop_clamp = bbps_pkg::DROP_MAX;
		end
	end

	assign y_new = bbps_pkg::sat24(bbps_pkg::sx36(y_q) + bbps_pkg::q16(prod));

	// operand select for the shared multiplier
	always_comb begin
		req.en = 1'b0;
		req.a  = '0;
		req.b  = '0;
		case (state_q)
			ST_IDLE: begin
				req.en = accept;
				req.a  = {5'b0, regs.gravity};
				req.b  = {9'b0, dt_clamp};
			end
			ST_VY_UPD: begin
				req.en = 1'b1;
				req.a  = bbps_pkg::sx25(vx_q);
				req.b  = {13'b0, dt_q};
			end
			ST_PX_UPD: begin
				req.en = 1'b1;
				req.a  = bbps_pkg::sx25(vy_q);
				req.b  = {13'b0, dt_q};
			end
			ST_PY_UPD, ST_KE_X: begin
				req.en = 1'b1;
				req.a  = bbps_pkg::sx25(vx_q);
				req.b  = bbps_pkg::sx25(vx_q);
			end
			ST_SQ_X, ST_DAMP_X: begin
				req.en = 1'b1;
				req.a  = bbps_pkg::sx25(vy_q);
				req.b  = bbps_pkg::sx25(vy_q);
			end
			ST_FLOOR: begin
				req.en = 1'b1;
				req.a  = -bbps_pkg::sx25(vy_q);
				req.b  = {9'b0, regs.damping};
			end
			ST_DAMP_Y: begin
				req.en = 1'b1;
				req.a  = bbps_pkg::sx25(vx_q);
				req.b  = {9'b0, regs.damping};
			end
			ST_WALL: begin
				req.en = 1'b1;
				req.a  = -bbps_pkg::sx25(vx_q);
				req.b  = {9'b0, regs.damping};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			y_q         <= 24'(bbps_pkg::DROP_RST);
			vx_q        <= '0;
			vy_q        <= '0;
			bounce_q    <= '0;
			rest_q      <= 1'b0;
			awaiting_q  <= 1'b1;
			e_init_q    <= '0;
			e_cur_q     <= '0;
			dt_q        <= '0;
			sq_q        <= '0;
			out_valid_q <= 1'b0;
			o_x_q       <= '0;
			o_y_q       <= '0;
			o_vx_q      <= '0;
			o_vy_q      <= '0;
			o_bounce_q  <= '0;
			o_rest_q    <= 1'b0;
			o_e_init_q  <= '0;
			o_e_cur_q   <= '0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || step_out.ready)) begin
				out_valid_q <= 1'b1;
			end else if (step_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (step_in.cmd) begin
							x_q        <= '0;
							y_q        <= 24'(drop_clamp);
							vx_q       <= '0;
							vy_q       <= '0;
							bounce_q   <= '0;
							rest_q     <= 1'b0;
							awaiting_q <= 1'b1;
							e_init_q   <= '0;
							e_cur_q    <= '0;
							state_q    <= ST_DONE;
						end else if (rest_q) begin
							state_q <= ST_DONE;
						end else begin
							dt_q    <= dt_clamp[11:0];
							state_q <= ST_VY_UPD;
						end
					end
				end
				ST_VY_UPD: begin
					vy_q    <= bbps_pkg::sat24(bbps_pkg::sx36(vy_q) - bbps_pkg::q16(prod));
					state_q <= ST_PX_UPD;
				end
				ST_PX_UPD: begin
					x_q     <= bbps_pkg::sat24(bbps_pkg::sx36(x_q) + bbps_pkg::q16(prod));
					state_q <= ST_PY_UPD;
				end
				ST_PY_UPD: begin
					if (y_new < bbps_pkg::RADIUS) begin
						y_q     <= bbps_pkg::RADIUS;
						state_q <= ST_SQ_X;
					end else begin
						y_q     <= y_new;
						state_q <= ST_WALL;
					end
				end
				ST_SQ_X, ST_KE_X: begin
					sq_q    <= prod[47:0];
					state_q <= (state_q == ST_SQ_X) ? ST_SQ_SUM : ST_KE_SUM;
				end
				ST_SQ_SUM, ST_KE_SUM: begin
					sq_q    <= sq_q + prod[47:0];
					state_q <= (state_q == ST_SQ_SUM) ? ST_FLOOR : ST_KE_LOAD;
				end
				ST_FLOOR: begin
					if (awaiting_q) begin
						e_init_q   <= bbps_pkg::kinetic(sq_q);
						awaiting_q <= 1'b0;
					end
					if (bounce_q != 16'hFFFF) begin
						bounce_q <= bounce_q + 16'd1;
					end
					if (sq_q < bbps_pkg::REST_SQ_LIMIT) begin
						vx_q    <= '0;
						vy_q    <= '0;
						rest_q  <= 1'b1;
						e_cur_q <= '0;
						state_q <= ST_WALL;
					end else begin
						state_q <= ST_DAMP_Y;
					end
				end
				ST_DAMP_Y: begin
					vy_q    <= bbps_pkg::sat24(bbps_pkg::q16(prod));
					state_q <= ST_DAMP_X;
				end
				ST_DAMP_X: begin
					vx_q    <= bbps_pkg::sat24(bbps_pkg::q16(prod));
					state_q <= ST_KE_X;
				end
				ST_KE_LOAD: begin
					e_cur_q <= bbps_pkg::kinetic(sq_q);
					state_q <= ST_WALL;
				end
				ST_WALL: begin
					if (x_q < bbps_pkg::WALL_NEG) begin
						x_q     <= bbps_pkg::WALL_NEG;
						state_q <= ST_WALL_DAMP;
					end else if (x_q > bbps_pkg::WALL_POS) begin
						x_q     <= bbps_pkg::WALL_POS;
						state_q <= ST_WALL_DAMP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WALL_DAMP: begin
					vx_q    <= bbps_pkg::sat24(bbps_pkg::q16(prod));
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || step_out.ready) begin
						o_x_q       <= x_q;
						o_y_q       <= y_q;
						o_vx_q      <= vx_q;
						o_vy_q      <= vy_q;
						o_bounce_q  <= bounce_q;
						o_rest_q    <= rest_q;
						o_e_init_q  <= e_init_q;
						o_e_cur_q   <= e_cur_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign step_out.valid        = out_valid_q;
	assign step_out.pos_x        = o_x_q;
	assign step_out.pos_y        = o_y_q;
	assign step_out.vel_x        = o_vx_q;
	assign step_out.vel_y        = o_vy_q;
	assign step_out.bounces      = o_bounce_q;
	assign step_out.resting      = o_rest_q;
	assign step_out.first_energy = o_e_init_q;
	assign step_out.last_energy  = o_e_cur_q;

	`include "bouncing_ball_physics_step_unit_assert.svh"

	`BBPS_ASSERT_IMP(a_rest_still, out_valid_q && o_rest_q, o_vx_q == 24'sd0 && o_vy_q == 24'sd0)
	`BBPS_ASSERT_IMP(a_above_floor, out_valid_q, o_y_q >= bbps_pkg::RADIUS)
	`BBPS_ASSERT_IMP(a_inside_walls, out_valid_q, o_x_q >= bbps_pkg::WALL_NEG && o_x_q <= bbps_pkg::WALL_POS)
	`BBPS_ASSERT_IMP(a_no_hit_energy, out_valid_q && o_bounce_q == 16'd0, (o_e_init_q | o_e_cur_q) == '0)
	`BBPS_ASSERT_NEXT(a_busy_after_take, step_in.valid && step_in.ready, !step_in.ready)

endmodule

### verif/bouncing_ball_physics_step_unit_tb.sv
module bouncing_ball_physics_step_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam longint     E_MAX     = 16777215;

	typedef struct {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic [15:0]        bounces;
		logic               resting;
		logic [23:0]        first_energy;
		logic [23:0]        last_energy;
	} step_word_t;

	logic clk = 1'b0;
	logic arst_n;

	bbps_in_if  step_in();
	bbps_out_if step_out();
	bbps_cfg_if cfg();

	bouncing_ball_physics_step_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_in  (step_in),
		.step_out (step_out),
		.cfg      (cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted ball state and register copies
	longint px, py, vx, vy;
	int     hits;
	bit     parked, unhit;
	longint e_first, e_last;
	longint cfg_drop, cfg_damp, cfg_grav;

	step_word_t predicted_words[$];
	int         failures = 0;
	bit         idle_on  = 1'b1;

	function automatic longint sat_s24(longint v);
		if (v > 8388607) begin
			return 8388607;
		end
		if (v < -8388608) begin
			return -8388608;
		end
		return v;
	endfunction

	// exact product, scaled down with floor rounding
	function automatic longint mul_floor16(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint energy_of(longint a, longint b);
		longint e;
		e = (a * a + b * b) >>> 17;
		return (e > E_MAX) ? E_MAX : e;
	endfunction

	function automatic void drop_ball();
		longint h;
		h = cfg_drop;
		if (h < bbps_pkg::DROP_MIN) begin
			h = bbps_pkg::DROP_MIN;
		end
		if (h > bbps_pkg::DROP_MAX) begin
			h = bbps_pkg::DROP_MAX;
		end
		px = 0;
		py = h;
		vx = 0;
		vy = 0;
		hits = 0;
		parked = 1'b0;
		unhit = 1'b1;
		e_first = 0;
		e_last = 0;
	endfunction

	function automatic void fly_ball(logic [15:0] dt_raw);
		longint dt;
		dt = (dt_raw > bbps_pkg::DT_MAX) ? longint'(bbps_pkg::DT_MAX) : longint'(dt_raw);
		if (parked) begin
			return;
		end
		vy = sat_s24(vy - mul_floor16(cfg_grav, dt));
		py = sat_s24(py + mul_floor16(vy, dt));
		px = sat_s24(px + mul_floor16(vx, dt));
		if (py < bbps_pkg::RADIUS) begin
			py = bbps_pkg::RADIUS;
			if (unhit) begin
				e_first = energy_of(vx, vy);
				unhit = 1'b0;
			end
			if (hits < 65535) begin
				hits++;
			end
			if (vx * vx + vy * vy < longint'(bbps_pkg::REST_SQ_LIMIT)) begin
				vx = 0;
				vy = 0;
				parked = 1'b1;
			end else begin
				vy = sat_s24(mul_floor16(-vy, cfg_damp));
				vx = sat_s24(mul_floor16(vx, cfg_damp));
			end
			e_last = energy_of(vx, vy);
		end
		if (px < bbps_pkg::WALL_NEG) begin
			px = bbps_pkg::WALL_NEG;
			vx = sat_s24(mul_floor16(-vx, cfg_damp));
		end
		if (px > bbps_pkg::WALL_POS) begin
			px = bbps_pkg::WALL_POS;
			vx = sat_s24(mul_floor16(-vx, cfg_damp));
		end
	endfunction

	function automatic step_word_t advance_ball(logic c, logic [15:0] dt_raw);
		step_word_t w;
		if (c) begin
			drop_ball();
		end else begin
			fly_ball(dt_raw);
		end
		w.pos_x = px[23:0];
		w.pos_y = py[23:0];
		w.vel_x = vx[23:0];
		w.vel_y = vy[23:0];
		w.bounces = hits[15:0];
		w.resting = parked;
		w.first_energy = e_first[23:0];
		w.last_energy = e_last[23:0];
		return w;
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s expected %0d actual %0d", name, exp_v, act_v);
			failures++;
		end
	endfunction

	function automatic logic [15:0] pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 16'($urandom_range(2500, 3277));
		end
		if (r < 85) begin
			return 16'($urandom_range(0, 3277));
		end
		if (r < 95) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(0, 40));
	endfunction

	task automatic send_step(input logic c, input logic [15:0] dt);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			step_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		step_in.valid <= 1'b1;
		step_in.cmd <= c;
		step_in.time_step <= dt;
		do @(posedge clk); while (!step_in.ready);
		predicted_words = {predicted_words, advance_ball(c, dt)};
	endtask

	// wait until every predicted word has come back
	task automatic settle();
		step_in.valid <= 1'b0;
		while (predicted_words.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			bbps_pkg::CFG_DROP_HEIGHT: cfg_drop = value[18:0];
			bbps_pkg::CFG_DAMPING:     cfg_damp = value[15:0];
			bbps_pkg::CFG_GRAVITY:     cfg_grav = value[19:0];
			default:                   ;
		endcase
	endtask

	task automatic set_regs(input logic [19:0] drop, input logic [19:0] damp,
		input logic [19:0] grav, input bit spare);
		write_reg(bbps_pkg::CFG_DROP_HEIGHT, drop);
		write_reg(bbps_pkg::CFG_DAMPING, damp);
		write_reg(bbps_pkg::CFG_GRAVITY, grav);
		if (spare) begin
			write_reg(CFG_SPARE, 20'($urandom));
		end
		cfg.valid <= 1'b0;
	endtask

	task automatic test_directed_steps();
		send_step(1'b0, 16'd0);
		send_step(1'b0, 16'hFFFF);
		send_step(1'b0, bbps_pkg::DT_MAX);
		send_step(1'b0, bbps_pkg::DT_MAX + 16'd1);
		send_step(1'b0, 16'd1);
		send_step(1'b1, 16'hFFFF);
		send_step(1'b0, 16'h8000);
		send_step(1'b1, 16'd0);
		// fall from the default height through the first floor contact
		repeat (16) send_step(1'b0, bbps_pkg::DT_MAX);
		settle();
	endtask

	task automatic test_drop_height_clamp();
		set_regs(20'd0, 20'(bbps_pkg::DAMP_RST), 20'(bbps_pkg::GRAV_RST), 1'b1);
		send_step(1'b1, 16'($urandom));
		send_step(1'b0, bbps_pkg::DT_MAX);
		settle();
		set_regs(20'hFFFFF, 20'hFFFFF, 20'(bbps_pkg::GRAV_RST), 1'b0);
		send_step(1'b1, 16'd0);
		send_step(1'b0, bbps_pkg::DT_MAX);
		settle();
		set_regs(20'(bbps_pkg::DROP_MIN) - 20'd1, 20'(bbps_pkg::DAMP_RST),
			20'(bbps_pkg::GRAV_RST), 1'b0);
		send_step(1'b1, 16'd0);
		settle();
		set_regs(20'(bbps_pkg::DROP_MAX) + 20'd1, 20'(bbps_pkg::DAMP_RST),
			20'(bbps_pkg::GRAV_RST), 1'b0);
		send_step(1'b1, 16'd0);
		settle();
		set_regs(20'(bbps_pkg::DROP_MIN), 20'(bbps_pkg::DAMP_RST),
			20'(bbps_pkg::GRAV_RST), 1'b0);
		send_step(1'b1, 16'd0);
		settle();
		set_regs(20'(bbps_pkg::DROP_MAX), 20'(bbps_pkg::DAMP_RST),
			20'(bbps_pkg::GRAV_RST), 1'b0);
		send_step(1'b1, 16'd0);
		settle();
	endtask

	task automatic test_random_flight();
		logic [19:0] drop, damp, grav;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					drop = 20'(bbps_pkg::DROP_RST);
					damp = 20'(bbps_pkg::DAMP_RST);
					grav = 20'(bbps_pkg::GRAV_RST);
				end
				1: begin
					drop = 20'(bbps_pkg::DROP_MAX);
					damp = 20'hFFFFF;
					grav = 20'hFFFFF;
				end
				2: begin
					drop = 20'(bbps_pkg::DROP_MIN);
					damp = 20'd0;
					grav = 20'd0;
				end
				default: begin
					case ($urandom_range(0, 3))
						0:       drop = 20'($urandom);
						1:       drop = 20'(bbps_pkg::DROP_MIN);
						2:       drop = 20'(bbps_pkg::DROP_MAX);
						default: drop = 20'($urandom_range(bbps_pkg::DROP_MIN,
							bbps_pkg::DROP_MAX));
					endcase
					case ($urandom_range(0, 3))
						0:       damp = 20'd0;
						1:       damp = 20'h0FFFF;
						default: damp = 20'($urandom);
					endcase
					case ($urandom_range(0, 3))
						0:       grav = 20'($urandom);
						1:       grav = 20'($urandom_range(0, 40000));
						default: grav = 20'($urandom_range(300000, 1048575));
					endcase
				end
			endcase
			set_regs(drop, damp, grav, phase == 3);
			idle_on = ($urandom_range(0, 3) != 0);
			send_step(1'b1, 16'($urandom));
			repeat (220) begin
				if ($urandom_range(0, 99) == 0) begin
					send_step(1'b1, 16'($urandom));
				end else begin
					send_step(1'b0, pick_step());
				end
			end
			settle();
		end
		idle_on = 1'b1;
	endtask

	// damping factor zero and strong gravity: after the first contact, a floor contact on every tick
	task automatic test_rapid_bounces();
		set_regs(20'(bbps_pkg::DROP_MIN), 20'd0, 20'hFFFFF, 1'b0);
		idle_on = 1'b0;
		send_step(1'b1, 16'd0);
		repeat (200) send_step(1'b0, bbps_pkg::DT_MAX);
		settle();
		idle_on = 1'b1;
		send_step(1'b1, 16'd0);
		repeat (5) send_step(1'b0, bbps_pkg::DT_MAX);
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		step_in.valid <= 1'b0;
		step_in.cmd <= 1'b0;
		step_in.time_step <= 16'd0;
		cfg.valid <= 1'b0;
		cfg.index <= bbps_pkg::CFG_DROP_HEIGHT;
		cfg.data <= 20'd0;
		cfg_drop = bbps_pkg::DROP_RST;
		cfg_damp = bbps_pkg::DAMP_RST;
		cfg_grav = bbps_pkg::GRAV_RST;
		drop_ball();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_steps();
		test_drop_height_clamp();
		test_random_flight();
		test_rapid_bounces();
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("bouncing_ball_physics_step_unit regression: pass");
		end else begin
			$display("bouncing_ball_physics_step_unit regression: fail");
		end
		$finish;
	end

	// result side: random stalls, then compare each word with the oldest prediction
	initial begin
		int         stall;
		step_word_t got, want;
		step_out.ready <= 1'b0;
		while (arst_n !== 1'b1) begin
			@(posedge clk);
		end
		forever begin
			stall = idle_on ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				step_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			step_out.ready <= 1'b1;
			do @(posedge clk); while (!step_out.valid);
			got.pos_x = step_out.pos_x;
			got.pos_y = step_out.pos_y;
			got.vel_x = step_out.vel_x;
			got.vel_y = step_out.vel_y;
			got.bounces = step_out.bounces;
			got.resting = step_out.resting;
			got.first_energy = step_out.first_energy;
			got.last_energy = step_out.last_energy;
			if (predicted_words.size() == 0) begin
				$error("word with no prediction waiting");
				failures++;
			end else begin
				want = predicted_words.pop_front();
				check_field("pos_x", want.pos_x, got.pos_x);
				check_field("pos_y", want.pos_y, got.pos_y);
				check_field("vel_x", want.vel_x, got.vel_x);
				check_field("vel_y", want.vel_y, got.vel_y);
				check_field("bounces", want.bounces, got.bounces);
				check_field("resting", want.resting, got.resting);
				check_field("first_energy", want.first_energy, got.first_energy);
				check_field("last_energy", want.last_energy, got.last_energy);
			end
		end
	end

	initial begin
		#20ms;
		$display("bouncing_ball_physics_step_unit regression: fail");
		$finish;
	end

endmodule
